/* sv/rfd_pkg.sv */
// Shared types, codes and constants of the RPC frame deframer.
package rfd_pkg;

    localparam int LEN_BITS_DEF = 16;
    localparam int MIN_FRAME    = 26;
    localparam int WORD_BYTES   = 4;
    localparam int AFTER_REQ    = 17;
    localparam int AFTER_METH   = 13;
    localparam int AFTER_INFO   = 5;
    localparam int CKSUM_TAIL   = 5;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int TDATA_W      = 64;

    localparam logic [7:0]  START_MARKER_RST  = 8'd2;
    localparam logic [7:0]  END_MARKER_RST    = 8'd3;
    localparam logic [15:0] MAX_FRAME_LEN_RST = 16'hFFFF;

    localparam logic [CFG_IDX_W-1:0] REG_START_MARKER  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END_MARKER    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_FRAME_LEN = 2'd2;

    localparam logic [2:0] KIND_REQ_ID    = 3'd0;
    localparam logic [2:0] KIND_METHOD    = 3'd1;
    localparam logic [2:0] KIND_ERR_INFO  = 3'd2;
    localparam logic [2:0] KIND_PAYLOAD   = 3'd3;
    localparam logic [2:0] KIND_FRAME_END = 3'd4;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_END_BAD  = 2'd1;
    localparam logic [1:0] STATUS_OVERRUN  = 2'd2;
    localparam logic [1:0] STATUS_BAD_LEN  = 2'd3;

    typedef enum logic [3:0] {
        PH_HUNT,
        PH_LEN,
        PH_REQLEN,
        PH_REQ,
        PH_METHLEN,
        PH_METH,
        PH_ERR,
        PH_INFOLEN,
        PH_INFO,
        PH_PAYLOAD,
        PH_SKIP
    } phase_t;

    typedef struct packed {
        logic [7:0]  start_marker;
        logic [7:0]  end_marker;
        logic [15:0] max_frame_len;
    } cfg_t;

    typedef struct packed {
        logic [2:0]         kind;
        logic [7:0]         data_byte;
        logic [1:0]         status;
        logic [15:0]        frame_len;
        logic signed [31:0] code_word;
    } result_t;

endpackage

/* sv/rpc_frame_deframer_core.sv */
// Top level of the RPC frame deframer: config port, parser and output stage.
//
// Takes one received byte per clock on the s_ stream and sustains one byte per
// cycle while the output stage has room: each byte passes an input register,
// a combinational parse step and a result register in the output stage before
// its result is presented on the m_ stream. The parse state is updated once per
// byte in that parse step. Each content
// byte of the request id, method name, error info and payload leaves as one
// transaction tagged by kind; a frame end, or a rejected length word, leaves
// one transaction carrying status, frame length and error code. Bytes that
// give no result leave nothing. A two-entry output stage keeps the input side
// running while one result waits on m_tready. Configuration writes are always
// ready and take effect the next cycle; write them only while the block is idle.
module rpc_frame_deframer_core
#(
    parameter int LEN_BITS = rfd_pkg::LEN_BITS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] byte_in
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [rfd_pkg::TDATA_W-1:0]       m_tdata,   // [7:0] data_byte, [9:8] status,
                                                         // [25:10] frame_len,
                                                         // [57:26] code_word, rest zero
    output logic [2:0]                        m_tuser,   // [2:0] kind
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rfd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rfd_pkg::CFG_DATA_W-1:0]    cfg_data
);

    rfd_pkg::cfg_t    cfg;
    rfd_pkg::result_t res;
    rfd_pkg::result_t out_res;
    logic             res_valid;
    logic             res_ready;

    rfd_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rfd_parser #(.LEN_BITS(LEN_BITS)) u_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .cfg       (cfg),
        .res_ready (res_ready),
        .res_valid (res_valid),
        .res       (res)
    );

    rfd_out_buf u_out
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (res_valid),
        .push_ready (res_ready),
        .push_data  (res),
        .pop_valid  (m_tvalid),
        .pop_ready  (m_tready),
        .pop_data   (out_res)
    );

    assign m_tuser = out_res.kind;
    assign m_tdata = {6'b0, out_res.code_word, out_res.frame_len,
                      out_res.status, out_res.data_byte};

    a_res_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_ready)
        else $error("result produced with no room in output stage");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser <= rfd_pkg::KIND_FRAME_END))
        else $error("result kind out of range");

    a_byte_no_summary: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != rfd_pkg::KIND_FRAME_END)) |-> (m_tdata[57:8] == '0))
        else $error("content byte carries frame summary fields");

    a_end_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == rfd_pkg::KIND_FRAME_END)) |-> (m_tdata[7:0] == '0))
        else $error("frame end carries a data byte");

endmodule

/* sv/rfd_cfg_regs.sv */
// Configuration register file of the RPC frame deframer.
module rfd_cfg_regs
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rfd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rfd_pkg::CFG_DATA_W-1:0]   cfg_data,
    output rfd_pkg::cfg_t                    cfg
);

    rfd_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_marker  <= rfd_pkg::START_MARKER_RST;
            cfg_reg.end_marker    <= rfd_pkg::END_MARKER_RST;
            cfg_reg.max_frame_len <= rfd_pkg::MAX_FRAME_LEN_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                rfd_pkg::REG_START_MARKER:  cfg_reg.start_marker  <= cfg_data[7:0];
                rfd_pkg::REG_END_MARKER:    cfg_reg.end_marker    <= cfg_data[7:0];
                rfd_pkg::REG_MAX_FRAME_LEN: cfg_reg.max_frame_len <= cfg_data[15:0];
                default:                    cfg_reg <= cfg_reg;
            endcase
        end
    end

endmodule

/* sv/rfd_parser.sv */
// Input byte register and frame parsing state machine.
module rfd_parser
#(
    parameter int LEN_BITS = rfd_pkg::LEN_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       in_byte,
    input  rfd_pkg::cfg_t    cfg,
    input  logic             res_ready,
    output logic             res_valid,
    output rfd_pkg::result_t res
);

    localparam int PW = LEN_BITS + 1;

    logic                in_valid_reg;
    logic [7:0]          in_byte_reg;
    logic                fire;

    rfd_pkg::phase_t     phase_reg, phase_next;
    logic [LEN_BITS-1:0] pos_reg, pos_next;
    logic [LEN_BITS-1:0] total_reg, total_next;
    logic [31:0]         shift_reg, shift_next;
    logic [LEN_BITS-1:0] rem_reg, rem_next;
    logic [31:0]         err_reg, err_next;
    logic                ovf_reg, ovf_next;

    logic [LEN_BITS-1:0] pos_inc;
    logic [31:0]         shift_inc;
    logic [LEN_BITS-1:0] rem_dec;
    logic [PW-1:0]       after;
    logic [PW-1:0]       need;
    logic [PW-1:0]       avail;
    logic                w_gt_avail;
    logic                end_hit;
    logic                pay_live;
    logic                len_bad;

    assign fire     = in_valid_reg && res_ready;
    assign in_ready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            in_byte_reg  <= '0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
            if (in_valid)
            begin
                in_byte_reg <= in_byte;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= rfd_pkg::PH_HUNT;
            pos_reg   <= '0;
            total_reg <= '0;
            shift_reg <= '0;
            rem_reg   <= '0;
            err_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            total_reg <= total_next;
            shift_reg <= shift_next;
            rem_reg   <= rem_next;
            err_reg   <= err_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_comb
    begin
        pos_inc   = pos_reg + 1'b1;
        shift_inc = {shift_reg[23:0], in_byte_reg};
        rem_dec   = rem_reg - 1'b1;

        case (phase_reg)
            rfd_pkg::PH_REQLEN:  after = PW'(rfd_pkg::AFTER_REQ);
            rfd_pkg::PH_METHLEN: after = PW'(rfd_pkg::AFTER_METH);
            default:             after = PW'(rfd_pkg::AFTER_INFO);
        endcase

        need       = {1'b0, pos_inc} + after;
        avail      = ({1'b0, total_reg} >= need) ? ({1'b0, total_reg} - need) : '0;
        w_gt_avail = shift_inc > 32'(avail);
        end_hit    = (phase_reg != rfd_pkg::PH_LEN) && (total_reg != '0) &&
                     (pos_reg == total_reg - 1'b1);
        pay_live   = ({1'b0, pos_reg} + PW'(rfd_pkg::CKSUM_TAIL)) < {1'b0, total_reg};
        len_bad    = (shift_inc < 32'(rfd_pkg::MIN_FRAME)) ||
                     (shift_inc > 32'(cfg.max_frame_len)) ||
                     ((shift_inc >> LEN_BITS) != '0);

        phase_next = phase_reg;
        pos_next   = pos_reg;
        total_next = total_reg;
        shift_next = shift_reg;
        rem_next   = rem_reg;
        err_next   = err_reg;
        ovf_next   = ovf_reg;
        res_valid  = 1'b0;
        res        = '0;

        if (fire)
        begin
            if (phase_reg == rfd_pkg::PH_HUNT)
            begin
                if (in_byte_reg == cfg.start_marker)
                begin
                    phase_next = rfd_pkg::PH_LEN;
                    pos_next   = LEN_BITS'(1);
                    total_next = '0;
                    err_next   = '0;
                    ovf_next   = 1'b0;
                    rem_next   = LEN_BITS'(rfd_pkg::WORD_BYTES);
                    shift_next = '0;
                end
            end
            else
            begin
                pos_next = pos_inc;
                if (end_hit)
                begin
                    phase_next     = rfd_pkg::PH_HUNT;
                    res_valid      = 1'b1;
                    res.kind       = rfd_pkg::KIND_FRAME_END;
                    res.status     = ovf_reg ? rfd_pkg::STATUS_OVERRUN :
                                     (in_byte_reg != cfg.end_marker) ?
                                     rfd_pkg::STATUS_END_BAD : rfd_pkg::STATUS_OK;
                    res.frame_len  = 16'(total_reg);
                    res.code_word  = err_reg;
                end
                else
                begin
                    case (phase_reg)
                        rfd_pkg::PH_REQ, rfd_pkg::PH_METH, rfd_pkg::PH_INFO:
                        begin
                            rem_next      = rem_dec;
                            res_valid     = 1'b1;
                            res.data_byte = in_byte_reg;
                            if (phase_reg == rfd_pkg::PH_REQ)
                            begin
                                res.kind = rfd_pkg::KIND_REQ_ID;
                            end
                            else if (phase_reg == rfd_pkg::PH_METH)
                            begin
                                res.kind = rfd_pkg::KIND_METHOD;
                            end
                            else
                            begin
                                res.kind = rfd_pkg::KIND_ERR_INFO;
                            end
                            if (rem_dec == '0)
                            begin
                                if (phase_reg == rfd_pkg::PH_INFO)
                                begin
                                    phase_next = rfd_pkg::PH_PAYLOAD;
                                end
                                else
                                begin
                                    phase_next = (phase_reg == rfd_pkg::PH_REQ) ?
                                                 rfd_pkg::PH_METHLEN : rfd_pkg::PH_ERR;
                                    rem_next   = LEN_BITS'(rfd_pkg::WORD_BYTES);
                                    shift_next = '0;
                                end
                            end
                        end
                        rfd_pkg::PH_PAYLOAD:
                        begin
                            if (pay_live)
                            begin
                                res_valid     = 1'b1;
                                res.kind      = rfd_pkg::KIND_PAYLOAD;
                                res.data_byte = in_byte_reg;
                            end
                        end
                        rfd_pkg::PH_SKIP:
                        begin
                            phase_next = rfd_pkg::PH_SKIP;
                        end
                        default:
                        begin
                            shift_next = shift_inc;
                            rem_next   = rem_dec;
                            if (rem_dec == '0)
                            begin
                                case (phase_reg)
                                    rfd_pkg::PH_LEN:
                                    begin
                                        if (len_bad)
                                        begin
                                            phase_next    = rfd_pkg::PH_HUNT;
                                            res_valid     = 1'b1;
                                            res.kind      = rfd_pkg::KIND_FRAME_END;
                                            res.status    = rfd_pkg::STATUS_BAD_LEN;
                                            res.frame_len = (shift_inc > 32'hFFFF) ?
                                                            16'hFFFF : shift_inc[15:0];
                                        end
                                        else
                                        begin
                                            total_next = shift_inc[LEN_BITS-1:0];
                                            phase_next = rfd_pkg::PH_REQLEN;
                                            rem_next   = LEN_BITS'(rfd_pkg::WORD_BYTES);
                                            shift_next = '0;
                                        end
                                    end
                                    rfd_pkg::PH_ERR:
                                    begin
                                        err_next   = shift_inc;
                                        phase_next = rfd_pkg::PH_INFOLEN;
                                        rem_next   = LEN_BITS'(rfd_pkg::WORD_BYTES);
                                        shift_next = '0;
                                    end
                                    default:
                                    begin
                                        if (w_gt_avail)
                                        begin
                                            ovf_next   = 1'b1;
                                            phase_next = rfd_pkg::PH_SKIP;
                                        end
                                        else if (shift_inc == '0)
                                        begin
                                            case (phase_reg)
                                                rfd_pkg::PH_REQLEN:
                                                    phase_next = rfd_pkg::PH_METHLEN;
                                                rfd_pkg::PH_METHLEN:
                                                    phase_next = rfd_pkg::PH_ERR;
                                                default:
                                                    phase_next = rfd_pkg::PH_PAYLOAD;
                                            endcase
                                            rem_next   = LEN_BITS'(rfd_pkg::WORD_BYTES);
                                            shift_next = '0;
                                        end
                                        else
                                        begin
                                            case (phase_reg)
                                                rfd_pkg::PH_REQLEN:
                                                    phase_next = rfd_pkg::PH_REQ;
                                                rfd_pkg::PH_METHLEN:
                                                    phase_next = rfd_pkg::PH_METH;
                                                default:
                                                    phase_next = rfd_pkg::PH_INFO;
                                            endcase
                                            rem_next = shift_inc[LEN_BITS-1:0];
                                        end
                                    end
                                endcase
                            end
                        end
                    endcase
                end
            end
        end
    end

endmodule

/* sv/rfd_out_buf.sv */
// Two-entry result register with skid slot toward the output stream.
module rfd_out_buf
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  rfd_pkg::result_t push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output rfd_pkg::result_t pop_data
);

    logic             main_valid_reg;
    logic             skid_valid_reg;
    rfd_pkg::result_t main_reg;
    rfd_pkg::result_t skid_reg;
    logic             pop;

    assign push_ready = !skid_valid_reg;
    assign pop_valid  = main_valid_reg;
    assign pop_data   = main_reg;
    assign pop        = main_valid_reg && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                main_valid_reg <= push_valid;
            end
        end
        else if (push_valid && push_ready)
        begin
            if (!main_valid_reg)
            begin
                main_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            main_reg <= skid_valid_reg ? skid_reg : push_data;
        end
        else if (push_valid && push_ready)
        begin
            if (!main_valid_reg)
            begin
                main_reg <= push_data;
            end
            else
            begin
                skid_reg <= push_data;
            end
        end
    end

endmodule
